// ===== hw/rtl/tsam_pkg.sv =====
// Package for the two-source audio mixer: sizes, register indexes and the
// item types that pass between the front end, the queue and the back end.
// No dependencies.
package tsam_pkg;

    localparam int FIFO_DEPTH  = 65536;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int PCM_W       = 16;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MIX_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_MODE = 1'd1;

    localparam logic signed [PCM_W-1:0] PCM_MAX = 16'sh7FFF;
    localparam logic signed [PCM_W-1:0] PCM_MIN = 16'sh8000;

    // Operation selected by func
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_MIX  = 1'b1;

    // Microphone item on its way to the back end, before the RAM read returns
    typedef struct packed {
        logic signed [PCM_W-1:0] mic;
        logic                    use_fifo;
        logic                    eop;
    } front_op_t;

    // Both operands of one mix, as held in the queue
    typedef struct packed {
        logic signed [PCM_W-1:0] mic;
        logic signed [PCM_W-1:0] second;
        logic                    eop;
    } mix_op_t;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(FIFO_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

endpackage

// ===== hw/rtl/tsam_if.sv =====
// Handshake channels of the mixer: input items and result items.
// Depends on tsam_pkg.
interface tsam_in_if
    import tsam_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    func;
    logic signed [PCM_W-1:0] sample_in;
    logic                    silent;
    logic                    end_of_packet;

    modport source (output valid, func, sample_in, silent, end_of_packet, input ready);
    modport sink   (input valid, func, sample_in, silent, end_of_packet, output ready);
endinterface

interface tsam_out_if
    import tsam_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [PCM_W-1:0] mixed_out;
    logic        [PCM_W-1:0] peak_level;
    logic                    packet_done;

    modport source (output valid, mixed_out, peak_level, packet_done, input ready);
    modport sink   (input valid, mixed_out, peak_level, packet_done, output ready);
endinterface

// ===== hw/rtl/tsam_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsam_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/tsam_front.sv =====
// Front end: configuration registers, input acceptance, FIFO pointers and the
// sample RAM. Depends on tsam_pkg, tsam_if and tsam_ram.
module tsam_front
    import tsam_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_wdata,
    tsam_in_if.sink              item,
    input  logic [QCNT_W-1:0]    q_count,
    output logic                 q_push,
    output mix_op_t              q_data
);

    logic             mix_enable_reg;
    logic             pause_mode_reg;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             s1_valid_reg, s1_valid_next;
    front_op_t        s1_op_reg;
    front_op_t        op_next;
    logic             accept;
    logic             do_push, do_pop, do_clear, do_mix;
    logic             full;
    logic [PCM_W-1:0] push_data;
    logic [PCM_W-1:0] ram_rdata;
    logic [QCNT_W:0]  occupancy;

    // Reserve queue room for the item sitting in the RAM read stage
    assign occupancy  = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(s1_valid_reg);
    assign item.ready = occupancy < (QCNT_W+1)'(QUEUE_DEPTH);
    assign accept     = item.valid && item.ready;

    assign full     = fill_reg == CNT_W'(FIFO_DEPTH);
    assign do_push  = accept && item.func == FUNC_PUSH && !pause_mode_reg && mix_enable_reg;
    assign do_clear = accept && item.func == FUNC_MIX && pause_mode_reg;
    assign do_mix   = accept && item.func == FUNC_MIX && !pause_mode_reg;
    assign do_pop   = do_mix && mix_enable_reg && fill_reg != '0;

    assign push_data = item.silent ? '0 : item.sample_in;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        fill_next   = fill_reg;
        if (do_clear)
        begin
            rd_ptr_next = '0;
            wr_ptr_next = '0;
            fill_next   = '0;
        end
        else if (do_push)
        begin
            wr_ptr_next = next_ptr(wr_ptr_reg);
            // drop the oldest entry when full
            if (full)
                rd_ptr_next = next_ptr(rd_ptr_reg);
            else
                fill_next = fill_reg + 1'b1;
        end
        else if (do_pop)
        begin
            rd_ptr_next = next_ptr(rd_ptr_reg);
            fill_next   = fill_reg - 1'b1;
        end
    end

    always_comb
    begin
        op_next.mic      = item.silent ? '0 : item.sample_in;
        op_next.use_fifo = do_pop;
        op_next.eop      = item.end_of_packet;
        s1_valid_next    = do_mix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_enable_reg <= 1'b0;
            pause_mode_reg <= 1'b0;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            fill_reg       <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MIX_ENABLE: mix_enable_reg <= cfg_wdata;
                    CFG_PAUSE_MODE: pause_mode_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            rd_ptr_reg   <= rd_ptr_next;
            wr_ptr_reg   <= wr_ptr_next;
            fill_reg     <= fill_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_mix)
            s1_op_reg <= op_next;
    end

    tsam_ram #(
        .WIDTH (PCM_W),
        .DEPTH (FIFO_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (do_push),
        .waddr (wr_ptr_reg),
        .wdata (push_data),
        .re    (do_pop),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // Join the returned sample with its item; zero when nothing was popped
    assign q_push        = s1_valid_reg;
    assign q_data.mic    = s1_op_reg.mic;
    assign q_data.second = s1_op_reg.use_fifo ? $signed(ram_rdata) : '0;
    assign q_data.eop    = s1_op_reg.eop;

endmodule

// ===== hw/rtl/tsam_queue.sv =====
// Short queue of mix operations between front end and back end.
// Depends on tsam_pkg.
module tsam_queue
    import tsam_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mix_op_t           push_data,
    input  logic              pop,
    output mix_op_t           head,
    output logic              not_empty,
    output logic [QCNT_W-1:0] count
);

    mix_op_t           slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QCNT_W-1:0] count_reg;

    assign head      = slot[rd_reg];
    assign not_empty = count_reg != '0;
    assign count     = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot[wr_reg] <= push_data;
    end

endmodule

// ===== hw/rtl/tsam_back.sv =====
// Back end: saturating add, packet peak meter and the result register.
// Depends on tsam_pkg and tsam_if.
module tsam_back
    import tsam_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  mix_op_t head,
    input  logic    not_empty,
    output logic    pop,
    tsam_out_if.source result
);

    logic                    out_valid_reg;
    logic signed [PCM_W-1:0] mixed_reg;
    logic        [PCM_W-1:0] peak_out_reg;
    logic                    done_reg;
    logic        [PCM_W-1:0] peak_reg, peak_next;
    logic signed [PCM_W:0]   sum;
    logic signed [PCM_W-1:0] sat;
    logic        [PCM_W-1:0] mag;
    logic        [PCM_W-1:0] new_peak;

    assign pop = not_empty && (!out_valid_reg || result.ready);

    always_comb
    begin
        sum = {head.mic[PCM_W-1], head.mic} + {head.second[PCM_W-1], head.second};
        if (sum[PCM_W] != sum[PCM_W-1])
            sat = sum[PCM_W] ? PCM_MIN : PCM_MAX;
        else
            sat = sum[PCM_W-1:0];
        mag      = sat[PCM_W-1] ? (PCM_W'(0) - sat) : sat;
        new_peak = (mag > peak_reg) ? mag : peak_reg;
        // restart the meter after the closing sample
        peak_next = head.eop ? '0 : new_peak;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            peak_reg      <= '0;
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= 1'b1;
                peak_reg      <= peak_next;
            end
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            mixed_reg    <= sat;
            peak_out_reg <= new_peak;
            done_reg     <= head.eop;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.mixed_out   = mixed_reg;
    assign result.peak_level  = peak_out_reg;
    assign result.packet_done = done_reg;

endmodule

// ===== hw/rtl/two_source_audio_mixer.sv =====
// Top level of the two-source audio mixer: front end, queue and back end.
// Depends on tsam_pkg, tsam_if, tsam_front, tsam_queue and tsam_back.
//
//   channel  | dir | payload                                   | transfer when
//   ---------+-----+-------------------------------------------+--------------------
//   item     | in  | func, sample_in, silent, end_of_packet    | valid && ready
//   result   | out | mixed_out, peak_level, packet_done        | valid && ready
//   cfg      | in  | cfg_index, cfg_wdata                      | cfg_we
//
// One item per cycle is sustained. A microphone item passes the registered read
// of the sample RAM and then the queue before it is loaded into the result
// register. Reset clears pointers, fill count, peak and the queue; the sample
// RAM keeps its contents, as every entry is written before it is read.
// The input stalls once the queue and the RAM read stage hold four items between
// them, which happens only behind a stalled result.
module two_source_audio_mixer
    import tsam_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_wdata,
    tsam_in_if.sink              item,
    tsam_out_if.source           result
);

    // Front end to queue
    logic              q_push;
    mix_op_t           q_push_data;
    logic [QCNT_W-1:0] q_count;

    // Queue to back end
    mix_op_t           q_head;
    logic              q_not_empty;
    logic              q_pop;

    // Accept items, keep the FIFO pointers and read the stored second source
    tsam_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item      (item),
        .q_count   (q_count),
        .q_push    (q_push),
        .q_data    (q_push_data)
    );

    // Hold mixes while the result side stalls
    tsam_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head      (q_head),
        .not_empty (q_not_empty),
        .count     (q_count)
    );

    // Add with saturation, advance the peak meter and present the result
    tsam_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .not_empty (q_not_empty),
        .pop       (q_pop),
        .result    (result)
    );

endmodule
